// ===== design/iobd_pkg.sv =====
// ----------------------------------------------------------------------------
// iobd_pkg
// Shared types and constants of the I/O bank decoder with beam counter.
// ----------------------------------------------------------------------------
package iobd_pkg;

   localparam logic [31:0] CIA_START    = 32'h00bf_e000;
   localparam logic [31:0] CIA_END      = 32'h00bf_f000;
   localparam logic [31:0] CUSTOM_START = 32'h00df_f000;
   localparam logic [31:0] CUSTOM_END   = 32'h00e0_0000;
   localparam logic [31:0] BEAM_ADDR    = 32'h00df_f006;
   localparam logic [31:0] BEAM_HI_ADDR = 32'h00df_f004;
   localparam logic [16:0] BEAM_STEP    = 17'h0_0101;

   localparam int CIA_DEPTH    = 4096;
   localparam int CUSTOM_DEPTH = 2048;
   localparam int CIA_AW       = $clog2(CIA_DEPTH);
   localparam int CUSTOM_AW    = $clog2(CUSTOM_DEPTH);

   localparam logic [CUSTOM_AW-1:0] BEAM_HI_INDEX = CUSTOM_AW'(2);
   localparam logic [CUSTOM_AW-1:0] BEAM_LO_INDEX = CUSTOM_AW'(3);
   localparam logic [CUSTOM_AW-1:0] LAST_INDEX    = CUSTOM_AW'(CUSTOM_DEPTH - 1);

   localparam int QUEUE_DEPTH_DEF = 2;

   localparam logic       OP_READ    = 1'b0;
   localparam logic       OP_WRITE   = 1'b1;
   localparam logic [1:0] SIZE_BYTE  = 2'd0;
   localparam logic [1:0] SIZE_SHORT = 2'd1;
   localparam logic [1:0] SIZE_LONG  = 2'd2;

   typedef enum logic [2:0] {
      KIND_BAD,
      KIND_CIA_RD,
      KIND_CIA_WR,
      KIND_CUS_RD,
      KIND_CUS_WR,
      KIND_CUS_LONG
   } kind_type;

   typedef enum logic [2:0] {
      ST_CLEAR = 3'b001,
      ST_ISSUE = 3'b010,
      ST_DATA  = 3'b100
   } back_state_type;

   typedef struct packed {
      kind_type              kind;
      logic [CIA_AW-1:0]     cia_index;
      logic [CUSTOM_AW-1:0]  word_index;
      logic                  second_ok;
      logic                  beam_step;
      logic [15:0]           wdata;
   } cmd_type;

endpackage

// ===== design/iobd_front.sv =====
// ----------------------------------------------------------------------------
// iobd_front
// Accepts bus accesses and decodes them into bank commands for the queue.
// ----------------------------------------------------------------------------
module iobd_front (
   input  logic               req_tvalid,
   output logic               req_tready,
   input  logic [63:0]        req_tdata,   // address, write_data
   input  logic [2:0]         req_tuser,   // operation, size
   input  logic               q_full,
   input  logic               clearing,
   output logic               push,
   output iobd_pkg::cmd_type  push_cmd
);

   logic        op;
   logic [1:0]  size;
   logic [31:0] addr;
   logic [31:0] wdata;
   logic        in_cia;
   logic        in_cus;
   iobd_pkg::kind_type kind;

   assign op    = req_tuser[0];
   assign size  = req_tuser[2:1];
   assign addr  = req_tdata[31:0];
   assign wdata = req_tdata[63:32];

   assign in_cia = (addr >= iobd_pkg::CIA_START) && (addr < iobd_pkg::CIA_END);
   assign in_cus = (addr >= iobd_pkg::CUSTOM_START) && (addr < iobd_pkg::CUSTOM_END);

   always_comb begin
      kind = iobd_pkg::KIND_BAD;
      if (in_cia) begin
         if (size == iobd_pkg::SIZE_BYTE) begin
            kind = (op == iobd_pkg::OP_WRITE) ? iobd_pkg::KIND_CIA_WR : iobd_pkg::KIND_CIA_RD;
         end
      end else if (in_cus) begin
         if (size == iobd_pkg::SIZE_SHORT) begin
            kind = (op == iobd_pkg::OP_WRITE) ? iobd_pkg::KIND_CUS_WR : iobd_pkg::KIND_CUS_RD;
         end else if (size == iobd_pkg::SIZE_LONG && op == iobd_pkg::OP_READ) begin
            kind = iobd_pkg::KIND_CUS_LONG;
         end
      end
   end

   always_comb begin
      push_cmd.kind       = kind;
      push_cmd.cia_index  = addr[iobd_pkg::CIA_AW-1:0];
      push_cmd.word_index = addr[iobd_pkg::CUSTOM_AW:1];
      push_cmd.second_ok  = addr[iobd_pkg::CUSTOM_AW:1] != iobd_pkg::LAST_INDEX;
      push_cmd.beam_step  =
         (kind == iobd_pkg::KIND_CUS_RD && addr == iobd_pkg::BEAM_ADDR) ||
         (kind == iobd_pkg::KIND_CUS_LONG &&
          (addr == iobd_pkg::BEAM_ADDR || addr == iobd_pkg::BEAM_HI_ADDR));
      push_cmd.wdata      = wdata[15:0];
   end

   assign req_tready = !q_full && !clearing;
   assign push       = req_tvalid && req_tready;

endmodule

// ===== design/iobd_queue.sv =====
// ----------------------------------------------------------------------------
// iobd_queue
// Small command FIFO between the decode front and the bank back end.
// ----------------------------------------------------------------------------
module iobd_queue #(
   parameter int DEPTH = iobd_pkg::QUEUE_DEPTH_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  iobd_pkg::cmd_type  push_cmd,
   output logic               full,
   input  logic               pop,
   output iobd_pkg::cmd_type  pop_cmd,
   output logic               empty
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   iobd_pkg::cmd_type entry_ff [DEPTH];
   logic [PTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]  count_ff, count_in;

   function automatic logic [PTR_W-1:0] ptr_next(input logic [PTR_W-1:0] p);
      logic [PTR_W-1:0] n;
      n = (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
      return n;
   endfunction

   assign full    = count_ff == CNT_W'(DEPTH);
   assign empty   = count_ff == '0;
   assign pop_cmd = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? ptr_next(wr_ptr_ff) : wr_ptr_ff;
      rd_ptr_in = pop ? ptr_next(rd_ptr_ff) : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

// ===== design/iobd_back.sv =====
// ----------------------------------------------------------------------------
// iobd_back
// Bank stores, beam position counter and result register.
// ----------------------------------------------------------------------------
module iobd_back (
   input  logic               clock,
   input  logic               reset,
   input  logic               q_empty,
   input  iobd_pkg::cmd_type  q_cmd,
   output logic               q_pop,
   output logic               clearing,
   output logic               rsp_tvalid,
   input  logic               rsp_tready,
   output logic [31:0]        rsp_tdata,   // read_data
   output logic               rsp_tuser    // access_ok
);

   localparam int CAW = iobd_pkg::CIA_AW;
   localparam int WAW = iobd_pkg::CUSTOM_AW;

   logic [7:0]  cia_mem [iobd_pkg::CIA_DEPTH];
   logic [15:0] cus_mem [iobd_pkg::CUSTOM_DEPTH];

   iobd_pkg::back_state_type state_ff, state_in;
   logic [CAW-1:0]    clr_cnt_ff, clr_cnt_in;
   iobd_pkg::cmd_type cmd_ff;
   logic [15:0]       beam_hi_ff, beam_hi_in;
   logic [15:0]       beam_lo_ff, beam_lo_in;
   logic [15:0]       snap_hi_ff, snap_lo_ff;
   logic [7:0]        cia_rd_ff;
   logic [15:0]       cus_a_ff, cus_b_ff;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [31:0]       rsp_data_ff;
   logic              rsp_ok_ff;

   logic              issue;
   logic              beam_word_wr;
   logic [WAW-1:0]    q_next_index;
   logic [WAW-1:0]    cmd_next_index;
   logic [16:0]       beam_sum;
   logic [15:0]       word_a, word_b;
   logic [31:0]       res_data;
   logic              res_ok;

   assign clearing  = state_ff == iobd_pkg::ST_CLEAR;
   assign issue     = (state_ff == iobd_pkg::ST_ISSUE) && !q_empty &&
                      (!rsp_valid_ff || rsp_tready);
   assign q_pop     = issue;

   assign beam_word_wr   = q_cmd.word_index == iobd_pkg::BEAM_HI_INDEX ||
                           q_cmd.word_index == iobd_pkg::BEAM_LO_INDEX;
   assign q_next_index   = q_cmd.word_index + WAW'(1);
   assign cmd_next_index = cmd_ff.word_index + WAW'(1);
   assign beam_sum       = {beam_hi_ff[0], beam_lo_ff} + iobd_pkg::BEAM_STEP;

   always_comb begin
      state_in   = state_ff;
      clr_cnt_in = clr_cnt_ff;
      unique case (state_ff)
         iobd_pkg::ST_CLEAR: begin
            clr_cnt_in = clr_cnt_ff + CAW'(1);
            if (clr_cnt_ff == CAW'(iobd_pkg::CIA_DEPTH - 1)) begin
               state_in = iobd_pkg::ST_ISSUE;
            end
         end
         iobd_pkg::ST_ISSUE: begin
            if (issue) begin
               state_in = iobd_pkg::ST_DATA;
            end
         end
         iobd_pkg::ST_DATA: begin
            state_in = iobd_pkg::ST_ISSUE;
         end
         default: begin
            state_in = iobd_pkg::ST_CLEAR;
         end
      endcase
   end

   always_comb begin
      beam_hi_in = beam_hi_ff;
      beam_lo_in = beam_lo_ff;
      if (issue) begin
         if (q_cmd.kind == iobd_pkg::KIND_CUS_WR) begin
            if (q_cmd.word_index == iobd_pkg::BEAM_HI_INDEX) begin
               beam_hi_in = q_cmd.wdata;
            end
            if (q_cmd.word_index == iobd_pkg::BEAM_LO_INDEX) begin
               beam_lo_in = q_cmd.wdata;
            end
         end
         if (q_cmd.beam_step) begin
            beam_hi_in = {15'd0, beam_sum[16]};
            beam_lo_in = beam_sum[15:0];
         end
      end
   end

   // beam words live in flops; their store entries are never used
   always_comb begin
      if (cmd_ff.word_index == iobd_pkg::BEAM_HI_INDEX) begin
         word_a = snap_hi_ff;
      end else if (cmd_ff.word_index == iobd_pkg::BEAM_LO_INDEX) begin
         word_a = snap_lo_ff;
      end else begin
         word_a = cus_a_ff;
      end
      if (cmd_next_index == iobd_pkg::BEAM_HI_INDEX) begin
         word_b = snap_hi_ff;
      end else if (cmd_next_index == iobd_pkg::BEAM_LO_INDEX) begin
         word_b = snap_lo_ff;
      end else begin
         word_b = cus_b_ff;
      end
   end

   always_comb begin
      res_data = '0;
      res_ok   = 1'b1;
      unique case (cmd_ff.kind)
         iobd_pkg::KIND_CIA_RD:   res_data = {24'd0, cia_rd_ff};
         iobd_pkg::KIND_CIA_WR:   res_data = '0;
         iobd_pkg::KIND_CUS_RD:   res_data = {{16{word_a[15]}}, word_a};
         iobd_pkg::KIND_CUS_WR:   res_data = '0;
         iobd_pkg::KIND_CUS_LONG: res_data = {word_a, cmd_ff.second_ok ? word_b : 16'd0};
         default: begin
            res_data = '0;
            res_ok   = 1'b0;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (state_ff == iobd_pkg::ST_DATA) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= iobd_pkg::ST_CLEAR;
         clr_cnt_ff   <= '0;
         beam_hi_ff   <= '0;
         beam_lo_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_cnt_ff   <= clr_cnt_in;
         beam_hi_ff   <= beam_hi_in;
         beam_lo_ff   <= beam_lo_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (issue) begin
         cmd_ff     <= q_cmd;
         snap_hi_ff <= beam_hi_ff;
         snap_lo_ff <= beam_lo_ff;
      end
      if (state_ff == iobd_pkg::ST_DATA) begin
         rsp_data_ff <= res_data;
         rsp_ok_ff   <= res_ok;
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == iobd_pkg::ST_CLEAR) begin
         cia_mem[clr_cnt_ff] <= '0;
      end else if (issue && q_cmd.kind == iobd_pkg::KIND_CIA_WR) begin
         cia_mem[q_cmd.cia_index] <= q_cmd.wdata[7:0];
      end
      if (issue) begin
         cia_rd_ff <= cia_mem[q_cmd.cia_index];
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == iobd_pkg::ST_CLEAR) begin
         cus_mem[clr_cnt_ff[WAW-1:0]] <= '0;
      end else if (issue && q_cmd.kind == iobd_pkg::KIND_CUS_WR && !beam_word_wr) begin
         cus_mem[q_cmd.word_index] <= q_cmd.wdata;
      end
      if (issue) begin
         cus_a_ff <= cus_mem[q_cmd.word_index];
         cus_b_ff <= cus_mem[q_next_index];
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_ok_ff;

endmodule

// ===== design/io_bank_decoder_with_beam_counter.sv =====
// ----------------------------------------------------------------------------
// io_bank_decoder_with_beam_counter
// Decodes bus accesses into the CIA byte bank and the custom word bank.
// An accepted item is queued, issued into the command and bank read registers, and
// then captured in the result register before the back end issues the next item.
// Up to QUEUE_DEPTH decoded items queue ahead of the bank back end.
// Reset: synchronous; then a clear sweep of both banks, req_tready low.
// ----------------------------------------------------------------------------
module io_bank_decoder_with_beam_counter #(
   parameter int QUEUE_DEPTH = iobd_pkg::QUEUE_DEPTH_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [63:0] req_tdata,   // [31:0] address, [63:32] write_data
   input  logic [2:0]  req_tuser,   // [0] operation, [2:1] size
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // [31:0] read_data
   output logic        rsp_tuser    // [0] access_ok
);

   logic              push;
   iobd_pkg::cmd_type push_cmd;
   logic              q_full;
   logic              q_empty;
   logic              q_pop;
   iobd_pkg::cmd_type q_cmd;
   logic              clearing;

   iobd_front u_front (
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .q_full     (q_full),
      .clearing   (clearing),
      .push       (push),
      .push_cmd   (push_cmd)
   );

   iobd_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_cmd (push_cmd),
      .full     (q_full),
      .pop      (q_pop),
      .pop_cmd  (q_cmd),
      .empty    (q_empty)
   );

   iobd_back u_back (
      .clock      (clock),
      .reset      (reset),
      .q_empty    (q_empty),
      .q_cmd      (q_cmd),
      .q_pop      (q_pop),
      .clearing   (clearing),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

endmodule

// ===== design/iobd_checker.sv =====
// ----------------------------------------------------------------------------
// iobd_checker
// Port-level checks of the I/O bank decoder, bound to the top level.
// ----------------------------------------------------------------------------
module iobd_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [31:0] rsp_tdata,
   input logic        rsp_tuser
);

   // bank clear sweep keeps the input closed right after reset
   a_clear_after_reset : assert property (@(posedge clock)
      reset |=> !req_tready)
      else $error("req_tready high right after reset");

   a_no_rsp_after_reset : assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("rsp_tvalid high right after reset");

   a_bad_reads_zero : assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser |-> rsp_tdata == 32'd0)
      else $error("bad access returned nonzero data");

   a_rsp_hold : assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("stalled item changed or dropped");

endmodule

bind io_bank_decoder_with_beam_counter iobd_checker u_iobd_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);

// ===== tb/io_bank_access_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// io_bank_access_checker
// Watches the access and result streams of the I/O bank decoder. It keeps its
// own copy of the CIA byte bank and the custom word bank, including the beam
// position, works out the result of every accepted access and compares it
// in order with the results that the decoder returns.
// ----------------------------------------------------------------------------
module io_bank_access_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [63:0] req_tdata,   // [31:0] address, [63:32] write_data
   input  logic [2:0]  req_tuser,   // [0] operation, [2:1] size
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [31:0] rsp_tdata,   // [31:0] read_data
   input  logic        rsp_tuser,   // [0] access_ok
   output int          mismatch_count,
   output int          outstanding
);

   typedef struct {
      logic [31:0] read_data;
      logic        access_ok;
   } access_result_type;

   logic [7:0]        cia_mem [iobd_pkg::CIA_DEPTH];
   logic [15:0]       custom_mem [iobd_pkg::CUSTOM_DEPTH];
   access_result_type result_q [$];

   initial begin
      mismatch_count = 0;
      outstanding    = 0;
   end

   function automatic logic in_cia(logic [31:0] a);
      return (a >= iobd_pkg::CIA_START) && (a < iobd_pkg::CIA_END);
   endfunction

   function automatic logic in_custom(logic [31:0] a);
      return (a >= iobd_pkg::CUSTOM_START) && (a < iobd_pkg::CUSTOM_END);
   endfunction

   // short read of the custom bank; the exact beam address bumps the counter
   function automatic logic [31:0] custom_short_read(logic [31:0] a);
      logic [15:0] w;
      logic [16:0] beam;
      w = custom_mem[a[11:1]];
      if (a == iobd_pkg::BEAM_ADDR) begin
         beam = {custom_mem[iobd_pkg::BEAM_HI_INDEX][0],
                 custom_mem[iobd_pkg::BEAM_LO_INDEX]} + iobd_pkg::BEAM_STEP;
         custom_mem[iobd_pkg::BEAM_HI_INDEX] = {15'd0, beam[16]};
         custom_mem[iobd_pkg::BEAM_LO_INDEX] = beam[15:0];
      end
      return {{16{w[15]}}, w};
   endfunction

   task automatic decode_access(input logic op, input logic [1:0] sz,
                                input logic [31:0] a, input logic [31:0] wd,
                                output access_result_type res);
      logic [31:0] hi;
      logic [31:0] lo;
      logic [31:0] cia_off;
      res.read_data = '0;
      res.access_ok = 1'b0;
      cia_off = a - iobd_pkg::CIA_START;
      if (in_cia(a)) begin
         if (sz == iobd_pkg::SIZE_BYTE) begin
            if (op == iobd_pkg::OP_READ) res.read_data = {24'd0, cia_mem[cia_off[11:0]]};
            else cia_mem[cia_off[11:0]] = wd[7:0];
            res.access_ok = 1'b1;
         end
      end else if (in_custom(a)) begin
         if (sz == iobd_pkg::SIZE_SHORT) begin
            if (op == iobd_pkg::OP_READ) res.read_data = custom_short_read(a);
            else custom_mem[a[11:1]] = wd[15:0];
            res.access_ok = 1'b1;
         end else if (sz == iobd_pkg::SIZE_LONG && op == iobd_pkg::OP_READ) begin
            hi = custom_short_read(a);
            lo = '0;
            if (in_custom(a + 32'd2)) lo = custom_short_read(a + 32'd2);
            res.read_data = {hi[15:0], lo[15:0]};
            res.access_ok = 1'b1;
         end
      end
   endtask

   always @(posedge clock) begin : monitor
      access_result_type want;
      access_result_type fresh;
      if (reset) begin
         foreach (cia_mem[i]) cia_mem[i] = '0;
         foreach (custom_mem[i]) custom_mem[i] = '0;
         result_q.delete();
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (result_q.size() == 0) begin
               $display("%0t: unexpected result item data %h ok %b",
                        $time, rsp_tdata, rsp_tuser);
               mismatch_count++;
            end else begin
               want = result_q.pop_front();
               if (rsp_tdata !== want.read_data) begin
                  $display("%0t: read_data expected %h actual %h",
                           $time, want.read_data, rsp_tdata);
                  mismatch_count++;
               end
               if (rsp_tuser !== want.access_ok) begin
                  $display("%0t: access_ok expected %b actual %b",
                           $time, want.access_ok, rsp_tuser);
                  mismatch_count++;
               end
            end
         end
         if (req_tvalid && req_tready) begin
            decode_access(req_tuser[0], req_tuser[2:1], req_tdata[31:0],
                          req_tdata[63:32], fresh);
            result_q.push_back(fresh);
         end
      end
      outstanding = result_q.size();
   end

endmodule

// ===== tb/tb_io_bank_decoder_with_beam_counter.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_io_bank_decoder_with_beam_counter
// Drives bus accesses into the I/O bank decoder: a directed set covering the
// bank edges, bad sizes, long reads over the bank end and the beam counter,
// then random accesses biased toward the banks. Both stream sides idle at
// random; the result side also holds off for long stretches so the decoder
// backs up. Checking is done by io_bank_access_checker.
// ----------------------------------------------------------------------------
module tb_io_bank_decoder_with_beam_counter;

   localparam logic [1:0] SIZE_RSVD   = 2'd3;
   localparam int         RANDOM_ITEMS = 750;
   localparam int         HOLD_CYCLES  = 300;
   localparam int         CYCLE_LIMIT  = 200000;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [63:0] req_tdata;   // [31:0] address, [63:32] write_data
   logic [2:0]  req_tuser;   // [0] operation, [2:1] size
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [31:0] rsp_tdata;   // [31:0] read_data
   logic        rsp_tuser;   // [0] access_ok

   int   mismatch_count;
   int   outstanding;
   int   cycle_count;
   logic sender_eager;
   logic receiver_eager;
   logic hold_rsp;

   io_bank_decoder_with_beam_counter DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   io_bank_access_checker u_checker (
      .clock          (clock),
      .reset          (reset),
      .req_tvalid     (req_tvalid),
      .req_tready     (req_tready),
      .req_tdata      (req_tdata),
      .req_tuser      (req_tuser),
      .rsp_tvalid     (rsp_tvalid),
      .rsp_tready     (rsp_tready),
      .rsp_tdata      (rsp_tdata),
      .rsp_tuser      (rsp_tuser),
      .mismatch_count (mismatch_count),
      .outstanding    (outstanding)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   initial cycle_count = 0;

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("tb_io_bank_decoder_with_beam_counter: errors");
         $finish;
      end
   end

   // enter after a handshake edge (or at start); leaves at the accepting edge
   task automatic send_access(input logic op, input logic [1:0] sz,
                              input logic [31:0] a, input logic [31:0] wd);
      int gap;
      if ($urandom_range(0, 15) == 0) sender_eager = ~sender_eager;
      gap = sender_eager ? 0 : $urandom_range(0, 14);
      @(negedge clock);
      if (gap != 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {wd, a};
      req_tuser  <= {sz, op};
      do @(posedge clock); while (!req_tready);
   endtask

   function automatic logic [31:0] bank_offset(int span);
      if ($urandom_range(0, 3) == 0) return 32'($urandom_range(0, span - 1));
      return 32'($urandom_range(0, 31));
   endfunction

   task automatic send_random_access();
      int          pick;
      logic        op;
      logic [1:0]  sz;
      logic [31:0] a;
      logic [31:0] wd;
      pick = $urandom_range(0, 99);
      op   = 1'($urandom_range(0, 1));
      wd   = $urandom();
      if (pick < 30) begin
         sz = iobd_pkg::SIZE_BYTE;
         a  = iobd_pkg::CIA_START + bank_offset(4096);
      end else if (pick < 55) begin
         sz = iobd_pkg::SIZE_SHORT;
         a  = iobd_pkg::CUSTOM_START + bank_offset(4096);
      end else if (pick < 67) begin
         op = iobd_pkg::OP_READ;
         sz = iobd_pkg::SIZE_LONG;
         if ($urandom_range(0, 4) == 0) begin
            a = iobd_pkg::CUSTOM_START + 32'($urandom_range(4088, 4095));
         end else begin
            a = iobd_pkg::CUSTOM_START + bank_offset(4096);
         end
      end else if (pick < 80) begin
         a = iobd_pkg::CUSTOM_START + 32'($urandom_range(0, 15));
         if ($urandom_range(0, 3) != 0) a = iobd_pkg::BEAM_ADDR;
         sz = ($urandom_range(0, 2) == 0) ? iobd_pkg::SIZE_LONG : iobd_pkg::SIZE_SHORT;
         if ($urandom_range(0, 4) != 0) op = iobd_pkg::OP_READ;
      end else if (pick < 90) begin
         sz = 2'($urandom_range(0, 3));
         a  = ($urandom_range(0, 1) == 0) ? iobd_pkg::CIA_START + bank_offset(4096)
                                          : iobd_pkg::CUSTOM_START + bank_offset(4096);
      end else begin
         sz = 2'($urandom_range(0, 3));
         a  = $urandom();
      end
      send_access(op, sz, a, wd);
   endtask

   initial begin
      rsp_tready     = 1'b0;
      receiver_eager = 1'b0;
      forever begin : receiver
         int stall;
         @(negedge clock);
         if (hold_rsp) begin
            rsp_tready <= 1'b0;
            repeat (HOLD_CYCLES) @(negedge clock);
            hold_rsp = 1'b0;
         end else begin
            if ($urandom_range(0, 15) == 0) receiver_eager = ~receiver_eager;
            stall = receiver_eager ? 0 : $urandom_range(0, 14);
            if (stall != 0) begin
               rsp_tready <= 1'b0;
               repeat (stall) @(negedge clock);
            end
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!rsp_tvalid);
      end
   end

   initial begin
      reset        = 1'b1;
      req_tvalid   = 1'b0;
      req_tdata    = '0;
      req_tuser    = '0;
      sender_eager = 1'b0;
      hold_rsp     = 1'b0;
      repeat (5) @(negedge clock);
      reset <= 1'b0;

      // bank edges, cleared contents, bad combinations
      send_access(iobd_pkg::OP_READ, iobd_pkg::SIZE_BYTE,
                  iobd_pkg::CIA_START, 32'h0);
      send_access(iobd_pkg::OP_WRITE, iobd_pkg::SIZE_BYTE,
                  iobd_pkg::CIA_START, 32'hffff_ffa5);
      send_access(iobd_pkg::OP_WRITE, iobd_pkg::SIZE_BYTE,
                  iobd_pkg::CIA_END - 32'd1, 32'h0000_00ff);
      send_access(iobd_pkg::OP_READ, iobd_pkg::SIZE_BYTE,
                  iobd_pkg::CIA_START, 32'h0);
      send_access(iobd_pkg::OP_READ, iobd_pkg::SIZE_BYTE,
                  iobd_pkg::CIA_END - 32'd1, 32'h0);
      send_access(iobd_pkg::OP_READ, iobd_pkg::SIZE_BYTE,
                  iobd_pkg::CIA_END, 32'h0);
      send_access(iobd_pkg::OP_READ, iobd_pkg::SIZE_SHORT,
                  iobd_pkg::CIA_START, 32'h0);
      send_access(iobd_pkg::OP_WRITE, iobd_pkg::SIZE_LONG,
                  iobd_pkg::CUSTOM_START, 32'hffff_ffff);
      send_access(iobd_pkg::OP_WRITE, iobd_pkg::SIZE_BYTE,
                  iobd_pkg::CUSTOM_START, 32'hffff_ffff);
      send_access(iobd_pkg::OP_READ, SIZE_RSVD,
                  iobd_pkg::CUSTOM_START, 32'h0);
      send_access(iobd_pkg::OP_WRITE, SIZE_RSVD,
                  iobd_pkg::CIA_START, 32'hffff_ffff);
      send_access(iobd_pkg::OP_READ, iobd_pkg::SIZE_BYTE,
                  32'h0, 32'h0);
      send_access(iobd_pkg::OP_WRITE, iobd_pkg::SIZE_SHORT,
                  32'hffff_ffff, 32'hffff_ffff);
      // sign extension, long read past the bank end
      send_access(iobd_pkg::OP_WRITE, iobd_pkg::SIZE_SHORT,
                  iobd_pkg::CUSTOM_END - 32'd2, 32'h0000_8001);
      send_access(iobd_pkg::OP_READ, iobd_pkg::SIZE_SHORT,
                  iobd_pkg::CUSTOM_END - 32'd1, 32'h0);
      send_access(iobd_pkg::OP_READ, iobd_pkg::SIZE_LONG,
                  iobd_pkg::CUSTOM_END - 32'd2, 32'h0);
      send_access(iobd_pkg::OP_READ, iobd_pkg::SIZE_LONG,
                  iobd_pkg::CUSTOM_END - 32'd4, 32'h0);
      // beam counter: wrap of the 17-bit position, odd address, long halves
      send_access(iobd_pkg::OP_WRITE, iobd_pkg::SIZE_SHORT,
                  iobd_pkg::BEAM_HI_ADDR, 32'h0000_ffff);
      send_access(iobd_pkg::OP_WRITE, iobd_pkg::SIZE_SHORT,
                  iobd_pkg::BEAM_ADDR, 32'h0000_ffff);
      send_access(iobd_pkg::OP_READ, iobd_pkg::SIZE_SHORT,
                  iobd_pkg::BEAM_ADDR, 32'h0);
      send_access(iobd_pkg::OP_READ, iobd_pkg::SIZE_LONG,
                  iobd_pkg::BEAM_HI_ADDR, 32'h0);
      send_access(iobd_pkg::OP_READ, iobd_pkg::SIZE_SHORT,
                  iobd_pkg::BEAM_ADDR + 32'd1, 32'h0);
      send_access(iobd_pkg::OP_READ, iobd_pkg::SIZE_LONG,
                  iobd_pkg::BEAM_ADDR, 32'h0);
      send_access(iobd_pkg::OP_READ, iobd_pkg::SIZE_LONG,
                  iobd_pkg::BEAM_HI_ADDR + 32'd1, 32'h0);
      send_access(iobd_pkg::OP_READ, iobd_pkg::SIZE_LONG,
                  iobd_pkg::CUSTOM_START, 32'h0);

      for (int i = 0; i < RANDOM_ITEMS; i++) begin
         if (i == 200 || i == 500) hold_rsp = 1'b1;
         send_random_access();
      end

      @(negedge clock);
      req_tvalid <= 1'b0;
      wait (outstanding == 0);
      repeat (20) @(posedge clock);
      if (mismatch_count == 0 && outstanding == 0) begin
         $display("tb_io_bank_decoder_with_beam_counter: clean");
      end else begin
         $display("tb_io_bank_decoder_with_beam_counter: errors");
      end
      $finish;
   end

endmodule
